/* src/hpf_pkg.sv */
package hpf_pkg;

    // Sample and coefficient widths fixed by the stream and register layout.
    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 15;
    localparam int COUNT_W  = 5;
    localparam int STATE_W  = 32;

    // Stage arithmetic widths: difference term, product and rounded result.
    localparam int DELTA_W = STATE_W + 2;
    localparam int PROD_W  = DELTA_W + COEFF_W + 1;
    localparam int Q15_SH  = 15;
    localparam int Y_W     = PROD_W - Q15_SH;

    // Rounding offset (one half in Q15) and the 16-bit saturation limits.
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);
    localparam logic signed [Y_W-1:0]    SAT_MAX    = Y_W'(32767);
    localparam logic signed [Y_W-1:0]    SAT_MIN    = -Y_W'(32768);

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic {
        REG_COEFF  = 1'b0,
        REG_STAGES = 1'b1
    } hpf_reg_t;

    // What one cell hands to its neighbor.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
    } hpf_link_t;

endpackage

/* src/hpf_cell.sv */
module hpf_cell
    import hpf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [COEFF_W-1:0]  alpha,
    input  logic                active,
    input  hpf_link_t           link_in,
    output hpf_link_t           link_out
);

    // Stage state: last input and last unsaturated output.
    logic signed [SAMPLE_W-1:0] x_prev_reg;
    logic signed [STATE_W-1:0]  y_prev_reg;

    // Middle pipeline register between the difference and the product.
    logic                       mid_valid_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic signed [SAMPLE_W-1:0] x_hold_reg;

    hpf_link_t                  out_reg;

    logic signed [DELTA_W-1:0]  delta_next;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [Y_W-1:0]      y_full;
    logic signed [SAMPLE_W-1:0] y_sat;

    // Difference term: y_prev + x - x_prev, exact in 34 bits.
    assign delta_next = DELTA_W'(y_prev_reg) + DELTA_W'(link_in.sample)
                        - DELTA_W'(x_prev_reg);

    // Q15 product rounded half up, then floor division by 32768.
    assign prod    = delta_reg * $signed({1'b0, alpha});
    assign rounded = prod + ROUND_HALF;
    assign y_full  = rounded[PROD_W-1:Q15_SH];

    // Saturate the exact result to the 16-bit sample range.
    always_comb begin
        if (y_full > SAT_MAX) begin
            y_sat = SAT_MAX[SAMPLE_W-1:0];
        end else if (y_full < SAT_MIN) begin
            y_sat = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            y_sat = y_full[SAMPLE_W-1:0];
        end
    end

    // First step: register the difference term and the incoming sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else begin
            mid_valid_reg <= link_in.valid;
        end
        if (link_in.valid) begin
            delta_reg  <= delta_next;
            x_hold_reg <= link_in.sample;
        end
    end

    // Second step: product, state update and hand-off to the next cell.
    // An inactive cell forwards the sample and keeps its state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
            x_prev_reg    <= '0;
            y_prev_reg    <= '0;
        end else begin
            out_reg.valid <= mid_valid_reg;
            if (mid_valid_reg && active) begin
                x_prev_reg <= x_hold_reg;
                y_prev_reg <= y_full[STATE_W-1:0];
            end
        end
        if (mid_valid_reg) begin
            out_reg.sample <= active ? y_sat : x_hold_reg;
        end
    end

    assign link_out = out_reg;

endmodule

/* src/cascaded_q15_highpass_filter.sv */
// Each cell registers the difference term, then the Q15 product. Only one item is in
// the chain, and the input reopens in the cycle after the result leaves the last cell,
// provided a result slot is free.
// Two result slots let an item be taken while the previous result waits for m_tready.
// Synchronous reset (aresetn low) clears stage state, config registers and all valids.
module cascaded_q15_highpass_filter
    import hpf_pkg::*;
#(
    parameter int MAX_STAGES = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_in

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata,   // [15:0] sample_out

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic [COEFF_W-1:0]     coeff_reg;
    logic [COUNT_W-1:0]     stages_reg;
    logic                   busy_reg;

    logic                   head_valid_reg;
    logic [SAMPLE_W-1:0]    head_data_reg;
    logic                   tail_valid_reg;
    logic [SAMPLE_W-1:0]    tail_data_reg;

    hpf_link_t              links [MAX_STAGES+1];
    logic [MAX_STAGES-1:0]  active;

    logic                   in_acc;
    logic                   cfg_wr;
    logic                   done;
    logic                   pop;
    hpf_reg_t               reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = hpf_reg_t'(paddr[2]);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg  <= '0;
            stages_reg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_COEFF:  coeff_reg  <= pwdata[COEFF_W-1:0];
                REG_STAGES: stages_reg <= pwdata[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_sel)
            REG_COEFF:  prdata = APB_DW'(coeff_reg);
            REG_STAGES: prdata = APB_DW'(stages_reg);
            default:    prdata = '0;
        endcase
    end

    // A cell works when the coefficient is nonzero and it lies below the stage count;
    // a count above the chain length thus covers every cell.
    always_comb begin
        for (int i = 0; i < MAX_STAGES; i++) begin
            active[i] = (coeff_reg != '0) && (32'(stages_reg) > i);
        end
    end

    // Input side: one item in the chain, and a free result slot for it.
    assign s_tready = !busy_reg && !tail_valid_reg;
    assign in_acc   = s_tvalid && s_tready;

    assign links[0].valid  = in_acc;
    assign links[0].sample = $signed(s_tdata);

    // Chain of identical cells.
    for (genvar g = 0; g < MAX_STAGES; g++) begin : g_cell
        hpf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .alpha    (coeff_reg),
            .active   (active[g]),
            .link_in  (links[g]),
            .link_out (links[g+1])
        );
    end

    assign done = links[MAX_STAGES].valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (in_acc) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    // Two-slot result buffer: head drives the output, tail holds a second result.
    assign pop = head_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end else begin
            if (done && !pop) begin
                if (!head_valid_reg) begin
                    head_valid_reg <= 1'b1;
                end else begin
                    tail_valid_reg <= 1'b1;
                end
            end else if (pop && !done) begin
                head_valid_reg <= tail_valid_reg;
                tail_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done && !pop) begin
            if (!head_valid_reg) begin
                head_data_reg <= links[MAX_STAGES].sample;
            end else begin
                tail_data_reg <= links[MAX_STAGES].sample;
            end
        end else if (pop && !done) begin
            head_data_reg <= tail_data_reg;
        end else if (pop && done) begin
            if (tail_valid_reg) begin
                head_data_reg <= tail_data_reg;
                tail_data_reg <= links[MAX_STAGES].sample;
            end else begin
                head_data_reg <= links[MAX_STAGES].sample;
            end
        end
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = head_data_reg;

    // A result leaves the chain only for an item that was taken in.
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> busy_reg)
        else $error("chain result without an item in flight");

    // An accepted item keeps the input closed in the next cycle.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (busy_reg && !s_tready))
        else $error("input open while an item is in the chain");

    // A finished result always finds a free slot.
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !(tail_valid_reg && !pop))
        else $error("result buffer overrun");

endmodule

/* dv/hpf_checker.sv */
module hpf_checker
    import hpf_pkg::*;
#(
    parameter int MAX_STAGES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,    // [15:0] sample_in

    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [SAMPLE_W-1:0] m_tdata,    // [15:0] sample_out

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic [APB_DW-1:0]   prdata,
    input  logic                pready,

    output int                  errors,
    output int                  outstanding
);

    localparam longint SAT_HI = 32767;
    localparam longint SAT_LO = -32768;

    // Mirror of the register file and of the per-stage filter state.
    logic [COEFF_W-1:0]         coeff;
    logic [COUNT_W-1:0]         stages_mirror;
    logic signed [SAMPLE_W-1:0] last_in  [MAX_STAGES];
    logic [STATE_W-1:0]         last_out [MAX_STAGES];

    logic [SAMPLE_W-1:0]        expected_samples [$];

    initial begin
        errors      = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                   input logic [SAMPLE_W-1:0] want);
        $display("[%0t] mismatch: %s (got %h, expected %h)", $realtime, what, got, want);
        errors = errors + 1;
    endtask

    // Runs one sample through the active stages and updates their state.
    function automatic logic [SAMPLE_W-1:0] filter_sample(input logic signed [SAMPLE_W-1:0] x_in);
        logic signed [SAMPLE_W-1:0] x;
        longint                     delta;
        longint                     y;
        int                         n;
        x = x_in;
        n = (stages_mirror > MAX_STAGES) ? MAX_STAGES : int'(stages_mirror);
        if (coeff != '0 && stages_mirror != '0) begin
            for (int i = 0; i < n; i++) begin
                delta = longint'($signed(last_out[i])) + longint'(x) - longint'(last_in[i]);
                y = (delta * longint'(coeff) + 64'sd16384) >>> 15;
                last_in[i]  = x;
                last_out[i] = 32'(y);
                if (y > SAT_HI) begin
                    x = 16'sh7fff;
                end else if (y < SAT_LO) begin
                    x = 16'sh8000;
                end else begin
                    x = 16'(y);
                end
            end
        end
        return x;
    endfunction

    // Watch the register port, the input item stream and the result stream.
    always @(posedge aclk) begin
        if (!aresetn) begin
            coeff         = '0;
            stages_mirror = '0;
            for (int i = 0; i < MAX_STAGES; i++) begin
                last_in[i]  = '0;
                last_out[i] = '0;
            end
            expected_samples.delete();
        end else begin
            if (psel && penable && pready && paddr[1:0] == 2'b00) begin
                if (pwrite) begin
                    case (hpf_reg_t'(paddr[APB_AW-1:2]))
                        REG_COEFF:  coeff         = pwdata[COEFF_W-1:0];
                        REG_STAGES: stages_mirror = pwdata[COUNT_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (hpf_reg_t'(paddr[APB_AW-1:2]))
                        REG_COEFF: begin
                            if (prdata != APB_DW'(coeff)) begin
                                report_mismatch("coefficient read back", 16'(prdata),
                                                16'(coeff));
                            end
                        end
                        REG_STAGES: begin
                            if (prdata != APB_DW'(stages_mirror)) begin
                                report_mismatch("stage count read back", 16'(prdata),
                                                16'(stages_mirror));
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if (s_tvalid && s_tready) begin
                expected_samples.push_back(filter_sample(s_tdata));
            end

            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("result item with no sample pending", m_tdata, 'x);
                end else if (m_tdata !== expected_samples[0]) begin
                    report_mismatch("sample_out", m_tdata, expected_samples[0]);
                    void'(expected_samples.pop_front());
                end else begin
                    void'(expected_samples.pop_front());
                end
            end
        end
        outstanding = expected_samples.size();
    end

endmodule

/* dv/testbench.sv */
module testbench;
    import hpf_pkg::*;

    localparam int MAX_STAGES = 4;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 2 * MAX_STAGES + 4;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    logic                calm     = 1'b0;
    int                  errors;
    int                  outstanding;
    int                  idle_cycles = 0;

    cascaded_q15_highpass_filter #(.MAX_STAGES(MAX_STAGES)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hpf_checker #(.MAX_STAGES(MAX_STAGES)) i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .errors(errors), .outstanding(outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // The result side stalls at random, except in the calm phase.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 29);
    end

    // Abort the run when nothing has moved on any port for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL cascaded_q15_highpass_filter");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One register access: setup phase, then access phase.
    task automatic reg_access(input logic write_en, input hpf_reg_t idx,
                              input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one item and waits until it is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random samples lean on full-scale steps, which stress the stage arithmetic most.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return SAMPLE_W'($urandom_range(16)) - 16'd8;
            3: return {$urandom_range(1) ? 1'b1 : 1'b0, 15'h7fff};
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Drain, reprogram both registers, read them back, then stream samples.
    // The wait before the drain loop lets the checker count the item taken at the last edge.
    task automatic run_phase(input int coeff, input int stages, input bit directed,
                             input int random_count);
        logic [SAMPLE_W-1:0] v;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        // Bits above each register's width are set at random; they must be dropped.
        reg_access(1'b1, REG_COEFF, APB_DW'(coeff) | ($urandom << COEFF_W));
        reg_access(1'b1, REG_STAGES, APB_DW'(stages) | ($urandom << COUNT_W));
        reg_access(1'b0, REG_COEFF, '0);
        reg_access(1'b0, REG_STAGES, '0);
        if (directed) begin
            for (int k = 0; k < 6; k++) begin
                case (k)
                    0, 2:    v = 16'h7fff;
                    1, 3:    v = 16'h8000;
                    4:       v = 16'h0000;
                    default: v = 16'hffff;
                endcase
                send_sample(v);
            end
        end
        for (int k = 0; k < random_count; k++) begin
            send_sample(pick_sample());
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration is a bypass.
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0001);

        run_phase(0, 0, 1'b0, 40);
        run_phase(32767, 4, 1'b1, 70);
        run_phase(1, 1, 1'b1, 50);
        calm <= 1'b1;
        run_phase(16384, 2, 1'b0, 80);
        calm <= 1'b0;
        run_phase(0, 3, 1'b0, 40);
        run_phase(30000, 0, 1'b0, 40);
        run_phase(32767, 16, 1'b1, 70);
        run_phase(29491, 31, 1'b0, 70);
        run_phase(20000, 3, 1'b0, 60);
        run_phase($urandom_range(32767), $urandom_range(31), 1'b0, 60);
        run_phase($urandom_range(32767), $urandom_range(31), 1'b0, 60);

        // Let the pipeline empty before the verdict.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS cascaded_q15_highpass_filter");
        end else begin
            $display("FAIL cascaded_q15_highpass_filter");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/hpf_pkg.sv
src/hpf_cell.sv
src/cascaded_q15_highpass_filter.sv
dv/hpf_checker.sv
dv/testbench.sv
